// ===== rtl/lecm_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lecm_pkg
// Shared types, key codes and the fixed command name table of the line editor.
// ----------------------------------------------------------------------------
package lecm_pkg;

    localparam logic [7:0] KEY_ENTER  = 8'h0D;
    localparam logic [7:0] KEY_DELETE = 8'h7F;

    localparam int TABLE_ROWS = 8;
    localparam int ROW_W      = 3;
    localparam int NAME_W     = 5;   // stored name length
    localparam int LEN_W      = 6;   // effective length, holds up to 63
    localparam int COL_W      = 5;   // character position within a name

    typedef enum logic [2:0] {
        S_IDLE,
        S_ROW,
        S_READ,
        S_CMP,
        S_DONE
    } t_state;

    typedef struct packed {
        logic edit;       // apply a plain character or delete, load its result
        logic start;      // line end taken: restart the table walk
        logic row_next;
        logic col_clear;
        logic col_next;
        logic rd_en;
        logic set_hit;
        logic load_line;  // load the line result and empty the line
    } t_ctrl_cmd;

    typedef struct packed {
        logic is_enter;
        logic row_end;
        logic row_short;
        logic char_eq;
        logic char_last;
        logic out_free;
    } t_dp_sts;

    function automatic logic [NAME_W-1:0] f_name_len(input logic [ROW_W-1:0] row);
        logic [NAME_W-1:0] len;
        unique case (row)
            3'd0:    len = 5'd5;
            3'd1:    len = 5'd4;
            3'd2:    len = 5'd4;
            3'd3:    len = 5'd10;
            3'd4:    len = 5'd5;
            3'd5:    len = 5'd8;
            3'd6:    len = 5'd7;
            3'd7:    len = 5'd9;
            default: len = 5'd0;
        endcase
        return len;
    endfunction

    // Names are right aligned in the vector, first character highest.
    function automatic logic [7:0] f_name_char(input logic [ROW_W-1:0] row,
                                               input logic [COL_W-1:0] col);
        logic [255:0]      name;
        logic [COL_W-1:0]  pos;
        unique case (row)
            3'd0:    name = 256'("start");
            3'd1:    name = 256'("stop");
            3'd2:    name = 256'("test");
            3'd3:    name = 256'("toggleDHCP");
            3'd4:    name = 256'("clear");
            3'd5:    name = 256'("changeIP");
            3'd6:    name = 256'("connect");
            3'd7:    name = 256'("getStatus");
            default: name = '0;
        endcase
        pos = f_name_len(row) - 5'd1 - col;
        return name[{pos, 3'b000} +: 8];
    endfunction

endpackage

// ===== rtl/lecm_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lecm_ctrl
// Controller: takes requests and sequences the command table walk.
// ----------------------------------------------------------------------------
module lecm_ctrl
    import lecm_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    input  t_dp_sts   i_sts,
    output logic      o_in_stall,
    output t_ctrl_cmd o_cmd
);

    t_state r_state;
    t_state n_state;
    logic   accept;

    assign o_in_stall = !((r_state == S_IDLE) && i_sts.out_free);
    assign accept     = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (accept && i_sts.is_enter) begin
                    n_state = S_ROW;
                end
            end
            S_ROW: begin
                if (i_sts.row_end) begin
                    n_state = S_DONE;
                end else if (!i_sts.row_short) begin
                    n_state = S_READ;
                end
            end
            S_READ: n_state = S_CMP;
            S_CMP: begin
                if (!i_sts.char_eq) begin
                    n_state = S_ROW;
                end else if (i_sts.char_last) begin
                    n_state = S_DONE;
                end else begin
                    n_state = S_READ;
                end
            end
            S_DONE: begin
                if (i_sts.out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd = '0;
        unique case (r_state)
            S_IDLE: begin
                o_cmd.edit  = accept && !i_sts.is_enter;
                o_cmd.start = accept && i_sts.is_enter;
            end
            S_ROW: begin
                if (!i_sts.row_end) begin
                    o_cmd.row_next  = i_sts.row_short;
                    o_cmd.col_clear = !i_sts.row_short;
                end
            end
            S_READ: o_cmd.rd_en = 1'b1;
            S_CMP: begin
                o_cmd.row_next = !i_sts.char_eq;
                o_cmd.set_hit  = i_sts.char_eq && i_sts.char_last;
                o_cmd.col_next = i_sts.char_eq && !i_sts.char_last;
            end
            S_DONE: o_cmd.load_line = i_sts.out_free;
            default: o_cmd = '0;
        endcase
    end

endmodule

// ===== rtl/lecm_dp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lecm_dp
// Datapath: line buffer memory, character count, name compare, result register.
// ----------------------------------------------------------------------------
module lecm_dp
    import lecm_pkg::*;
#(
    parameter int LINE_LEN     = 64,
    parameter int NUM_COMMANDS = 8,
    parameter int NAME_LEN     = 16
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic [7:0]      i_rx_char,
    input  logic            i_out_stall,
    input  t_ctrl_cmd       i_cmd,
    output t_dp_sts         o_sts,
    output logic            o_out_valid,
    output logic [7:0]      o_echo_char,
    output logic            o_line_done,
    output logic            o_matched,
    output logic [ROW_W-1:0] o_command_index
);

    localparam int CW        = $clog2(LINE_LEN + 1);
    localparam int AW        = $clog2(LINE_LEN);
    localparam int CMPW      = (CW > LEN_W) ? CW : LEN_W;
    localparam int ROW_LIMIT = (NUM_COMMANDS > TABLE_ROWS) ? TABLE_ROWS : NUM_COMMANDS;

    logic [7:0]       mem [LINE_LEN];
    logic [7:0]       r_rd_data;
    logic [CW-1:0]    r_count;
    logic [CW-1:0]    n_count;
    logic [ROW_W:0]   r_row;
    logic [LEN_W-1:0] r_col;
    logic             r_hit;
    logic [7:0]       r_char;

    logic             r_out_valid;
    logic [7:0]       r_echo;
    logic             r_done;
    logic             r_match;
    logic [ROW_W-1:0] r_index;

    logic [NAME_W-1:0] name_len;
    logic [LEN_W-1:0]  eff_len;
    logic              is_delete;
    logic              wr_en;

    assign name_len  = f_name_len(r_row[ROW_W-1:0]);
    assign eff_len   = (LEN_W'(name_len) > LEN_W'(NAME_LEN)) ? LEN_W'(NAME_LEN)
                                                             : LEN_W'(name_len);
    assign is_delete = (i_rx_char == KEY_DELETE);
    assign wr_en     = i_cmd.edit && !is_delete && (r_count < CW'(LINE_LEN));

    assign o_sts.is_enter  = (i_rx_char == KEY_ENTER);
    assign o_sts.row_end   = (r_row >= (ROW_W + 1)'(ROW_LIMIT));
    assign o_sts.row_short = CMPW'(eff_len) > CMPW'(r_count);
    assign o_sts.char_eq   = (r_rd_data == f_name_char(r_row[ROW_W-1:0], r_col[COL_W-1:0]));
    assign o_sts.char_last = (r_col == eff_len - LEN_W'(1));
    assign o_sts.out_free  = !r_out_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[AW'(r_count)] <= i_rx_char;
        end
        if (i_cmd.rd_en) begin
            r_rd_data <= mem[AW'(r_col)];
        end
    end

    always_comb begin
        n_count = r_count;
        if (i_cmd.load_line) begin
            n_count = '0;
        end else if (i_cmd.edit) begin
            if (is_delete) begin
                if (r_count != '0) begin
                    n_count = r_count - CW'(1);
                end
            end else if (wr_en) begin
                n_count = r_count + CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_count <= n_count;
            if (i_cmd.edit || i_cmd.load_line) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Walk counters and result payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_row  <= '0;
            r_hit  <= 1'b0;
            r_char <= i_rx_char;
        end else if (i_cmd.row_next) begin
            r_row <= r_row + (ROW_W + 1)'(1);
        end
        if (i_cmd.set_hit) begin
            r_hit <= 1'b1;
        end
        if (i_cmd.col_clear) begin
            r_col <= '0;
        end else if (i_cmd.col_next) begin
            r_col <= r_col + LEN_W'(1);
        end

        if (i_cmd.edit) begin
            r_echo  <= i_rx_char;
            r_done  <= 1'b0;
            r_match <= 1'b0;
            r_index <= '0;
        end else if (i_cmd.load_line) begin
            r_echo  <= r_char;
            r_done  <= 1'b1;
            r_match <= r_hit;
            r_index <= r_hit ? r_row[ROW_W-1:0] : '0;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_echo_char     = r_echo;
    assign o_line_done     = r_done;
    assign o_matched       = r_match;
    assign o_command_index = r_index;

endmodule

// ===== rtl/line_edit_command_matcher.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// line_edit_command_matcher
// Terminal line editor with echo and prefix match against a command table.
// ----------------------------------------------------------------------------
// Every request yields one result that echoes the byte. A plain byte or a
// delete is taken and its result shows the next cycle. A carriage return
// starts a walk over the command table held in the package: each name row
// is tried in turn, an end of table step follows when no name matched, each
// compared character takes a line buffer memory read, then a compare, and
// the result is loaded last. A line such as "toggleDHCX" compares 18
// characters over all rows of the default table. No request is taken
// during the walk or while a result is held. The line is emptied when the
// line result is loaded.
module line_edit_command_matcher
    import lecm_pkg::*;
#(
    parameter int LINE_LEN     = 64,
    parameter int NUM_COMMANDS = 8,
    parameter int NAME_LEN     = 16
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic [7:0] i_rx_char,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic [7:0] o_echo_char,
    output logic       o_line_done,
    output logic       o_matched,
    output logic [2:0] o_command_index
);

    t_ctrl_cmd cmd;
    t_dp_sts   sts;

    lecm_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_sts      (sts),
        .o_in_stall (o_in_stall),
        .o_cmd      (cmd)
    );

    lecm_dp #(
        .LINE_LEN     (LINE_LEN),
        .NUM_COMMANDS (NUM_COMMANDS),
        .NAME_LEN     (NAME_LEN)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_rx_char       (i_rx_char),
        .i_out_stall     (i_out_stall),
        .i_cmd           (cmd),
        .o_sts           (sts),
        .o_out_valid     (o_out_valid),
        .o_echo_char     (o_echo_char),
        .o_line_done     (o_line_done),
        .o_matched       (o_matched),
        .o_command_index (o_command_index)
    );

    // A held result must block new requests.
    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |-> o_in_stall)
        else $error("request taken while result held");

    a_match_needs_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_matched) |-> o_line_done)
        else $error("match flagged without line end");

    a_idle_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_line_done) |-> (!o_matched && o_command_index == 3'd0))
        else $error("index set on a non line end");

    a_plain_one_cycle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall && i_rx_char != KEY_ENTER) |=>
            (o_out_valid && o_echo_char == $past(i_rx_char)))
        else $error("plain byte result missing");

endmodule
